// ===== hdl/b2da_pkg.sv =====
`default_nettype none
package b2da_pkg;

  // Width of the digit count field on the result channel.
  localparam int unsigned DCNT_W = 5;

  // Width of the character field on the result channel.
  localparam int unsigned CHAR_W = 6;

  // ASCII code of the character '0'.
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // A BCD digit at or above this value is corrected before each shift.
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD   = 4'd3;

  typedef logic [3:0] bcd_digit_t;

endpackage
`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_core.sv =====
`default_nettype none
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------------
// input    | in        | in_valid_i / in_ready_o   | value_i
// result   | out       | out_valid_o / out_ready_i | char_code_o, digit_count_o, last_o
//
// One value is converted at a time. The bit-serial shift-add-3 pass runs
// over all VALUE_WIDTH bits, the leading-zero strip then drops suppressed
// digits one at a time, and then one digit leaves per cycle while
// out_ready_i is high. A new value is accepted only after the last digit
// of the previous one has left.
// in_ready_o is high only while no conversion is in flight. A stalled result
// holds its payload. Reset returns the block to idle; data registers are not
// reset.
module binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       char_code_o,
  output logic [4:0]       digit_count_o,
  output logic             last_o
);
  import b2da_pkg::*;

  localparam int unsigned BCD_W = MAX_DIGITS * 4;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH + 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DCNT_W-1:0]      ndig_q, ndig_d;
  logic [DCNT_W-1:0]      remain_q, remain_d;
  logic                   ovf_q, ovf_d;
  bcd_digit_t             top_digit;

  // The most significant BCD digit is what both the strip and the emit look at.
  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // Add-3 correction, applied to every digit independently before each shift.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= BCD_ADJ_LIMIT) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    bin_d     = bin_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    ndig_d    = ndig_q;
    remain_d  = remain_q;
    ovf_d     = ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          bin_d     = value_i[VALUE_WIDTH-1:0];
          bcd_d     = '0;
          bit_cnt_d = BIT_CNT_W'(VALUE_WIDTH);
          ovf_d     = 1'b0;
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        // Shift the next binary bit into the corrected BCD register. Anything
        // pushed out of the top digit means the value has more digits than
        // the register holds; only the low digits are kept then.
        bcd_d     = {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
        ovf_d     = ovf_q | bcd_adj[BCD_W-1];
        bin_d     = {bin_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == BIT_CNT_W'(1)) begin
          ndig_d  = DCNT_W'(MAX_DIGITS);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits one per cycle, keeping at least one digit.
        // A truncated result keeps all of its digits, zeros included.
        if (!ovf_q && (ndig_q != DCNT_W'(1)) && (top_digit == 4'd0)) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          remain_d = ndig_q;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          bcd_d    = {bcd_q[BCD_W-5:0], 4'd0};
          remain_d = remain_q - 1'b1;
          if (remain_q == DCNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Data path registers need no reset: each is loaded before it is used, when a
  // transaction is accepted, when the shift-add-3 pass ends or when the strip ends.
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bit_cnt_q <= bit_cnt_d;
    ndig_q    <= ndig_d;
    remain_q  <= remain_d;
    ovf_q     <= ovf_d;
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign char_code_o   = ASCII_ZERO + {2'b00, top_digit};
  assign digit_count_o = ndig_q;
  assign last_o        = (remain_q == DCNT_W'(1));

endmodule
`default_nettype wire

// ===== tb/binary_to_decimal_ascii_core_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of the converter. Every accepted value is turned into its
// expected run of digit characters. Every accepted result is compared with the
// oldest digit still due.
module binary_to_decimal_ascii_core_checker #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_DIGITS  = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [63:0] value_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [5:0]  char_code_i,
  input  wire logic [4:0]  digit_count_i,
  input  wire logic        last_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      digits_due_o
);

  import b2da_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [DCNT_W-1:0] digit_count;
    logic              last;
  } digit_char_t;

  digit_char_t digits_due[$];

  initial begin
    mismatch_count_o = 0;
    digits_due_o     = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count_o < 50) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    mismatch_count_o++;
  endtask

  // Leading zeros are never produced because division stops once the rest is zero.
  // A run always holds at least one digit.
  task automatic queue_decimal_digits(input logic [63:0] value);
    logic [63:0] rest;
    logic [3:0]  dec[20];
    int          n;
    digit_char_t c;
    rest = (VALUE_WIDTH >= 64) ? value : (value & ((64'd1 << VALUE_WIDTH) - 64'd1));
    n = 0;
    do begin
      dec[n] = 4'(rest % 64'd10);
      rest   = rest / 64'd10;
      n++;
    end while (rest != 0 && n < MAX_DIGITS);
    for (int k = 0; k < n; k++) begin
      c.char_code   = ASCII_ZERO + CHAR_W'(dec[n - 1 - k]);
      c.digit_count = DCNT_W'(n);
      c.last        = (k == n - 1);
      digits_due.push_back(c);
    end
  endtask

  always @(posedge clk_i) begin
    digit_char_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d count %0d last %0b",
                                    char_code_i, digit_count_i, last_i));
        end else begin
          want = digits_due.pop_front();
          if (char_code_i !== want.char_code)
            report_mismatch($sformatf("char_code %0d, want %0d",
                                      char_code_i, want.char_code));
          if (digit_count_i !== want.digit_count)
            report_mismatch($sformatf("digit_count %0d, want %0d",
                                      digit_count_i, want.digit_count));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last_i, want.last));
        end
      end
      if (in_valid_i && in_ready_i) begin
        queue_decimal_digits(value_i);
      end
      digits_due_o = digits_due.size();
    end
  end

endmodule

// ===== tb/binary_to_decimal_ascii_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the binary to decimal ASCII converter.
// This module only creates stimulus and reports the verdict. The checker next to
// the DUT predicts every digit and counts mismatches.
module binary_to_decimal_ascii_core_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  char_code_o;
  logic [4:0]  digit_count_o;
  logic        last_o;

  int unsigned mismatch_count;
  int unsigned digits_due;

  // Chance, in percent, that the sender keeps idling before a transaction.
  // The same applies to the receiver holding off a result.
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;

  // Powers of ten from 10^0 to 10^19. They are used to aim values at the
  // boundaries where the digit count changes.
  logic [63:0] pow10[20];

  always #6 clk_i = ~clk_i;

  binary_to_decimal_ascii_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

  binary_to_decimal_ascii_core_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .char_code_i      (char_code_o),
    .digit_count_i    (digit_count_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .digits_due_o     (digits_due)
  );

  // The receiver makes a new ready decision at every falling edge. As a result,
  // stalls can land on any digit of a run, including the last one.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // This task starts and ends at a falling edge. Valid stays high at the end, so
  // back-to-back transactions assign valid only once per time step. While the
  // sender idles, the payload carries random noise.
  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The random mix aims at every digit count. It uses full-width values (mostly
  // 19 or 20 digits), values cut to a random bit width, values just around a power of
  // ten, and small values.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int unsigned w;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ;
      1: begin
        w = $urandom_range(64, 1);
        v = v >> (64 - w);
      end
      2: v = pow10[$urandom_range(19)] + 64'($urandom_range(4)) - 64'd2;
      default: v = 64'($urandom_range(999));
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] directed[$];
    pow10[0] = 64'd1;
    for (int i = 1; i < 20; i++) pow10[i] = pow10[i-1] * 64'd10;

    // The directed list covers these cases:
    // - zero
    // - single-digit values
    // - every kind of digit-count boundary
    // - the largest 64-bit value
    // - alternating bit patterns
    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd999,
                 64'd1000, 64'd1_000_000_000, 64'hFFFF_FFFF, 64'h1_0000_0000,
                 pow10[18] - 64'd1, pow10[18], pow10[19] - 64'd1, pow10[19],
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_value(directed[i]);

    // The four pacing phases are no idling, a slow sender, a slow receiver, and
    // both sides slow.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (105) send_value(random_value());
    end
    in_valid_i <= 1'b0;

    // Wait for every predicted digit to be delivered. After that, allow about one
    // conversion time more, so that any extra result still shows up.
    while (digits_due != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[binary_to_decimal_ascii_core] OK");
    end else begin
      $display("[binary_to_decimal_ascii_core] ERROR");
    end
    $finish;
  end

  // This is a safety net for a hung handshake or for results that never arrive.
  // A correct run needs well under a tenth of this time.
  initial begin
    #10ms;
    $display("[binary_to_decimal_ascii_core] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/b2da_pkg.sv
hdl/binary_to_decimal_ascii_core.sv
tb/binary_to_decimal_ascii_core_checker.sv
tb/binary_to_decimal_ascii_core_tb.sv
